### sv/pls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants of the positional list store
// Operation codes, item field widths and the result record handed from the
// sequencer to the output stage.
// ----------------------------------------------------------------------------
package pls_pkg;

  // Item field widths
  localparam int MODE_W = 2;
  localparam int POS_W  = 5;
  localparam int WORD_W = 32;
  localparam int CNT_W  = 5;

  // Operation codes carried in the mode field
  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND   = 2'd0,
    MODE_INSERT   = 2'd1,
    MODE_REMOVE   = 2'd2,
    MODE_RETRIEVE = 2'd3
  } mode_t;

  // One result item
  typedef struct packed {
    logic              success;
    logic [WORD_W-1:0] read_data;
    logic [CNT_W-1:0]  item_count;
    logic              is_empty;
  } pls_res_t;

endpackage

### sv/pls_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_mem: entry storage of the positional list store
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pls_mem #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_WIDTH-1:0]    wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_WIDTH-1:0]    rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry every cycle
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/pls_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_seq: request sequencer of the positional list store
// Checks a request against the entry count; insert and remove then move entries
// one at a time through the storage with a shared index incrementer/decrementer.
// ----------------------------------------------------------------------------
module pls_seq #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pls_pkg::mode_t                   mode,
  input  logic [pls_pkg::POS_W-1:0]        position,
  input  logic [pls_pkg::WORD_W-1:0]       entry_data,
  output logic                             res_valid,
  input  logic                             res_ack,
  output pls_pkg::pls_res_t                res
);

  import pls_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_PUT,
    ST_GRAB,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    K_PUT,
    K_DEL,
    K_GET
  } kind_t;

  state_t                state;
  kind_t                 kind;
  logic [CW-1:0]         count;
  logic [AW-1:0]         ptr;
  logic [AW-1:0]         end_idx;
  logic [DATA_WIDTH-1:0] data;
  logic                  ok;
  logic [WORD_W-1:0]     rdata;

  logic [PW-1:0]         pos_w;
  logic [PW-1:0]         cnt_w;
  logic                  room;
  logic                  pos_ok;
  logic                  ins_ok;
  logic [AW-1:0]         from_idx;
  logic [AW-1:0]         src;
  logic                  accept;

  logic                  wr_en;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] rd_data;

  // Check the request against the current count
  always_comb begin
    pos_w    = PW'(position);
    cnt_w    = PW'(count);
    room     = count < CW'(DEPTH);
    pos_ok   = (pos_w != '0) && (pos_w <= cnt_w);
    ins_ok   = room && (pos_w != '0) && (pos_w <= cnt_w + PW'(1));
    from_idx = AW'(pos_w - PW'(1));
  end

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Shared index unit: step toward the source entry of the next move
  assign src = ptr + ((kind == K_PUT) ? {AW{1'b1}} : AW'(1));

  // Storage port control
  assign rd_addr = (state == ST_MOVE_RD) ? src : from_idx;
  assign wr_en   = (state == ST_MOVE_WR) || (state == ST_PUT);
  assign wr_data = (state == ST_PUT) ? data : rd_data;

  pls_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ptr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result record
  always_comb begin
    res            = '0;
    res.success    = ok;
    res.read_data  = rdata;
    res.item_count = CNT_W'(count);
    res.is_empty   = (count == '0);
  end
  assign res_valid = (state == ST_FINISH);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            rdata <= '0;
            data  <= DATA_WIDTH'(entry_data);
            case (mode)
              MODE_APPEND: begin
                if (room) begin
                  kind    <= K_PUT;
                  ptr     <= AW'(count);
                  end_idx <= AW'(count);
                  count   <= count + CW'(1);
                  ok      <= 1'b1;
                  state   <= ST_MOVE_RD;
                end else begin
                  ok    <= 1'b0;
                  state <= ST_FINISH;
                end
              end
              MODE_INSERT: begin
                if (ins_ok) begin
                  kind    <= K_PUT;
                  ptr     <= AW'(count);
                  end_idx <= from_idx;
                  count   <= count + CW'(1);
                  ok      <= 1'b1;
                  state   <= ST_MOVE_RD;
                end else begin
                  ok    <= 1'b0;
                  state <= ST_FINISH;
                end
              end
              MODE_REMOVE: begin
                if (pos_ok) begin
                  kind    <= K_DEL;
                  ptr     <= from_idx;
                  end_idx <= AW'(count - CW'(1));
                  count   <= count - CW'(1);
                  ok      <= 1'b1;
                  state   <= ST_MOVE_RD;
                end else begin
                  ok    <= 1'b0;
                  state <= ST_FINISH;
                end
              end
              default: begin
                if (pos_ok) begin
                  kind  <= K_GET;
                  ok    <= 1'b1;
                  state <= ST_GRAB;
                end else begin
                  ok    <= 1'b0;
                  state <= ST_FINISH;
                end
              end
            endcase
          end
        end
        ST_MOVE_RD: begin
          if (ptr == end_idx) begin
            state <= (kind == K_PUT) ? ST_PUT : ST_FINISH;
          end else begin
            state <= ST_MOVE_WR;
          end
        end
        ST_MOVE_WR: begin
          ptr   <= src;
          state <= ST_MOVE_RD;
        end
        ST_PUT: begin
          state <= ST_FINISH;
        end
        ST_GRAB: begin
          rdata <= WORD_W'(rd_data);
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (res_ack) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // The count never passes the capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above capacity");

  // A move never overwrites the slot that closes the gap
  a_move_addr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOVE_WR) |-> (ptr != end_idx))
    else $error("entry move hit its end slot");

  // Without a new item the count holds
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && !accept) |=> (count == $past(count)))
    else $error("count changed with no item");

  // A rejected request leaves the count as it was
  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.success) |-> (count == $past(count)))
    else $error("rejected request changed the count");
`endif

endmodule

### sv/positional_list_store_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store_unit: ordered list with 1-based positional access
// Append, insert, remove and retrieve on a list of up to DEPTH words; one
// result item for every request item.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  ---------+-----------+----------------------------------------------------
//  s_*      | in        | request: mode, position, entry_data
//  m_*      | out       | result: success, read_data, item_count, is_empty
//
//  Steps: a rejected request goes straight to its result and a retrieve reads
//  one entry; append writes its entry; insert moves entries up and then writes
//  its entry, and remove moves entries down, one entry move at a time as a
//  read state and then a write state over the single storage write and read port.
//  Reset: synchronous clear of the sequencer and entry count; no memory sweep.
//  Stalls: s_tready is low while a request is worked on; a finished result
//  waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module positional_list_store_unit #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position[4:0], entry_data[36:5], zero[39:37]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // read_data[31:0], item_count[36:32],
                                 // is_empty[37], zero[39:38]
  output logic [0:0]  m_tuser    // success[0]
);

  import pls_pkg::*;

  logic     res_valid;
  logic     res_ack;
  pls_res_t res;
  pls_res_t res_q;

  pls_seq #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .mode       (mode_t'(s_tuser)),
    .position   (s_tdata[POS_W-1:0]),
    .entry_data (s_tdata[POS_W+WORD_W-1:POS_W]),
    .res_valid  (res_valid),
    .res_ack    (res_ack),
    .res        (res)
  );

  // Take a finished result when the output register is free or draining
  assign res_ack = res_valid && (!m_tvalid || m_tready);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (res_ack) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      res_q <= res;
    end
  end

  // Pack the result item
  assign m_tdata = {2'b00, res_q.is_empty, res_q.item_count, res_q.read_data};
  assign m_tuser = res_q.success;

endmodule

### dv/positional_list_store_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store_unit_test: self-checking bench for the list store
// Drives append, insert, remove and retrieve items through the request
// stream and predicts every result from a local copy of the list. Each
// result is checked field by field. Both streams idle in random bursts, and
// the tail of the run is sent back to back.
// ----------------------------------------------------------------------------
module positional_list_store_unit_test;
  import pls_pkg::*;

  localparam int DEPTH        = 16;
  localparam int DATA_WIDTH   = 32;
  localparam int RANDOM_ITEMS = 800;
  localparam int TAIL_ITEMS   = 100;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;

  // One request item as queued for the driver
  typedef struct {
    mode_t             op;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] word;
  } list_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // position[4:0], entry_data[36:5], zero[39:37]
  logic [1:0]  s_tuser = '0;   // mode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // read_data[31:0], item_count[36:32], is_empty[37]
  logic [0:0]  m_tuser;        // success[0]

  list_req_t   list_requests[$];
  pls_res_t    awaited_results[$];

  // Local copy of the list contents, updated on every accepted item
  logic [WORD_W-1:0] list_words[DEPTH];
  int unsigned       list_len;

  // Length of the list as seen while items are generated
  int unsigned       gen_len;

  bit          req_taken;
  int          idle_cycles;
  int          fail_count;
  int          src_gap;
  int          sink_gap;
  bit          src_calm;
  bit          sink_calm;

  positional_list_store_unit #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the local list and return the result it yields
  function automatic pls_res_t apply_list_op(mode_t op, logic [POS_W-1:0] pos,
                                             logic [WORD_W-1:0] word);
    pls_res_t    res;
    int unsigned p;
    int unsigned i;
    res = '0;
    p   = pos;
    case (op)
      MODE_APPEND: begin
        if (list_len < DEPTH) begin
          list_words[list_len] = word;
          list_len++;
          res.success = 1'b1;
        end
      end
      MODE_INSERT: begin
        if (list_len < DEPTH && p >= 1 && p <= list_len + 1) begin
          // open a slot: entries from the position on move up
          for (i = list_len; i > p - 1; i--) list_words[i] = list_words[i - 1];
          list_words[p - 1] = word;
          list_len++;
          res.success = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (p >= 1 && p <= list_len) begin
          // close the gap: later entries move down
          for (i = p - 1; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
          list_len--;
          res.success = 1'b1;
        end
      end
      default: begin
        if (p >= 1 && p <= list_len) begin
          res.read_data = list_words[p - 1];
          res.success   = 1'b1;
        end
      end
    endcase
    res.item_count = CNT_W'(list_len);
    res.is_empty   = (list_len == 0);
    return res;
  endfunction

  // Queue one request and track the list length it leaves behind
  task automatic queue_req(mode_t op, int unsigned pos, logic [WORD_W-1:0] word);
    list_req_t req;
    req.op       = op;
    req.position = POS_W'(pos);
    req.word     = word;
    list_requests.push_back(req);
    case (op)
      MODE_APPEND: if (gen_len < DEPTH) gen_len++;
      MODE_INSERT: if (gen_len < DEPTH && pos >= 1 && pos <= gen_len + 1) gen_len++;
      MODE_REMOVE: if (pos >= 1 && pos <= gen_len) gen_len--;
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [WORD_W-1:0] want,
                             logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Present request items; hold each until it is taken
  always @(negedge clk) begin
    list_req_t req;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (!src_calm && src_gap == 0 && list_requests.size() >= TAIL_ITEMS &&
          $urandom_range(0, 3) == 0)
        src_gap = $urandom_range(1, 7);
      if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (list_requests.size() != 0) begin
        req = list_requests.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, req.word, req.position};
        s_tuser  <= req.op;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    if ($urandom_range(0, 63) == 0) src_calm = !src_calm;
  end

  // Stall the result stream in bursts; stay ready through the tail
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_tready <= 1'b0;
    end else if (!sink_calm && list_requests.size() >= TAIL_ITEMS &&
                 $urandom_range(0, 4) == 0) begin
      sink_gap = $urandom_range(1, 7) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
    if ($urandom_range(0, 63) == 0) sink_calm = !sink_calm;
  end

  // Predict on each taken request and check each delivered result
  always @(posedge clk) begin
    pls_res_t want;
    if (rst) begin
      req_taken   = 1'b0;
      idle_cycles = 0;
    end else begin
      req_taken = s_tvalid && s_tready;
      if (req_taken)
        awaited_results.push_back(apply_list_op(mode_t'(s_tuser), s_tdata[4:0],
                                                s_tdata[36:5]));
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual tdata %h tuser %b",
                   $time, m_tdata, m_tuser);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("success", want.success, m_tuser[0]);
          check_field("read_data", want.read_data, m_tdata[31:0]);
          check_field("item_count", want.item_count, m_tdata[36:32]);
          check_field("is_empty", want.is_empty, m_tdata[37]);
        end
      end
      if (req_taken || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned top;
    bit          grow;
    list_len   = 0;
    gen_len    = 0;
    fail_count = 0;
    src_gap    = 0;
    sink_gap   = 0;
    src_calm   = 1'b0;
    sink_calm  = 1'b0;

    // Directed: empty list rejects, position bounds, full list rejects
    queue_req(MODE_RETRIEVE, 1, '0);
    queue_req(MODE_REMOVE, 1, '0);
    queue_req(MODE_INSERT, 0, 32'h1234_5678);
    queue_req(MODE_INSERT, 2, 32'h1234_5678);
    queue_req(MODE_INSERT, 1, 32'hFFFF_FFFF);
    queue_req(MODE_APPEND, 31, 32'h0000_0000);
    queue_req(MODE_INSERT, 3, 32'hA5A5_A5A5);
    queue_req(MODE_INSERT, 31, 32'h5A5A_5A5A);
    queue_req(MODE_RETRIEVE, 0, '0);
    queue_req(MODE_RETRIEVE, 3, '0);
    queue_req(MODE_RETRIEVE, 4, '0);
    queue_req(MODE_REMOVE, 4, '0);
    queue_req(MODE_REMOVE, 1, '0);
    while (gen_len < DEPTH) queue_req(MODE_APPEND, 0, $urandom);
    queue_req(MODE_APPEND, 0, 32'hDEAD_BEEF);
    queue_req(MODE_INSERT, 1, 32'hDEAD_BEEF);
    queue_req(MODE_RETRIEVE, DEPTH, '0);
    queue_req(MODE_RETRIEVE, DEPTH + 1, '0);
    queue_req(MODE_REMOVE, DEPTH, '0);

    // Random: grow and shrink phases of well-formed requests, plus noise
    grow = 1'b0;
    repeat (RANDOM_ITEMS) begin
      if (gen_len == DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
      else if (gen_len == 0 && $urandom_range(0, 3) == 0) grow = 1'b1;
      else if ($urandom_range(0, 39) == 0) grow = !grow;
      top  = (gen_len == 0) ? 1 : gen_len;
      pick = $urandom_range(0, 99);
      if (pick < 10)
        queue_req(mode_t'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom);
      else if (pick < 16)
        queue_req(mode_t'($urandom_range(1, 3)), gen_len + $urandom_range(0, 2),
                  $urandom);
      else if (pick < 38)
        queue_req(MODE_RETRIEVE, $urandom_range(1, top), '0);
      else if (grow && pick < 69)
        queue_req(MODE_APPEND, $urandom_range(0, 31), $urandom);
      else if (grow)
        queue_req(MODE_INSERT, $urandom_range(1, gen_len + 1), $urandom);
      else
        queue_req(MODE_REMOVE, $urandom_range(1, top), $urandom);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Run until everything is taken and answered, or the stream stalls
    while ((list_requests.size() != 0 || s_tvalid || awaited_results.size() != 0) &&
           idle_cycles < STALL_LIMIT)
      @(posedge clk);
    if (idle_cycles < STALL_LIMIT) repeat (DRAIN_CYCLES) @(posedge clk);

    if (idle_cycles >= STALL_LIMIT || awaited_results.size() != 0) begin
      $display("%0t: stream stalled with %0d results outstanding",
               $time, awaited_results.size());
      $display("RESULT: ERROR");
    end else if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
